// ===== rtl/core/shared_channel_poll_master_top_macros.svh =====
// Assertion macros shared by the checker of the poll master.
// Depends on nothing; included by the checker file.
`ifndef SHARED_CHANNEL_POLL_MASTER_TOP_MACROS_SVH
`define SHARED_CHANNEL_POLL_MASTER_TOP_MACROS_SVH
// implication checked every clock, disabled during reset
`define SCPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SCPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/scpm_pkg.sv =====
// Package of the shared channel poll master: widths, codes, result type.
// No dependencies.
`default_nettype none
package scpm_pkg;
   localparam int unsigned SLOTS_DEF = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [2:0] OP_TX_SLOT = 3'd0;
   localparam logic [2:0] OP_BCAST   = 3'd1;
   localparam logic [2:0] OP_ACK     = 3'd2;
   localparam logic [2:0] OP_BURST   = 3'd3;
   localparam logic [2:0] OP_SEND    = 3'd4;
   localparam logic [2:0] OP_CLOSED  = 3'd5;

   localparam logic [3:0] K_POLL_BEGIN = 4'd0;
   localparam logic [3:0] K_POLL       = 4'd1;
   localparam logic [3:0] K_POLL_END   = 4'd2;
   localparam logic [3:0] K_ADDR_AVAIL = 4'd3;
   localparam logic [3:0] K_CHAN_AVAIL = 4'd4;
   localparam logic [3:0] K_BUSY       = 4'd5;
   localparam logic [3:0] K_NEW_SLAVE  = 4'd6;
   localparam logic [3:0] K_DATA       = 4'd7;
   localparam logic [3:0] K_URGENT     = 4'd8;
   localparam logic [3:0] K_CLOSED     = 4'd9;

   localparam logic [2:0] R_NET_IDENT   = 3'd0;
   localparam logic [2:0] R_BUDGET_INIT = 3'd1;
   localparam logic [2:0] R_INTERVAL    = 3'd2;
   localparam logic [2:0] R_TIMEOUT     = 3'd3;
   localparam logic [2:0] R_BURST       = 3'd4;
   localparam logic [2:0] R_CONTROL     = 3'd5;
   localparam logic [2:0] R_REQ_ADDR    = 3'd6;
   localparam logic [2:0] R_CONFIRM     = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_NO_ADDR = 2'd2;

   localparam logic [15:0] ADDR_BCAST = 16'hFFFF;
   localparam logic [15:0] ADDR_SIG2  = 16'hFFFE;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  channel;
      logic [31:0] now;
      logic [15:0] src_address;
      logic [47:0] msg_body;
      logic        extra_bytes;
      logic [31:0] target_device;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  out_channel;
      logic [3:0]  kind;
      logic [15:0] address;
      logic [31:0] device;
      logic [3:0]  slot;
      logic        found;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] net_ident;
      logic [7:0]  budget_init;
      logic [15:0] interval;
      logic [15:0] timeout;
      logic [7:0]  burst;
      logic [7:0]  control_code;
      logic [7:0]  req_addr_code;
      logic [7:0]  confirm_code;
   } csr_type;

   // one table entry as stored in memory
   typedef struct packed {
      logic [31:0] device;
      logic [15:0] address;
      logic [31:0] last_rx;
      logic [15:0] timeout;
      logic [15:0] interval;
      logic [7:0]  burst;
      logic [7:0]  poll_tally;
      logic [31:0] due_at;
   } entry_type;
endpackage
`default_nettype wire

// ===== rtl/core/scpm_if.sv =====
// Valid/ready channel interface carrying one word of type T.
// Depends on scpm_pkg types passed as parameter.
`default_nettype none
interface scpm_if #(parameter type T = logic) (input wire logic clock);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/shared_channel_poll_master_top.sv =====
// Top level of the shared channel poll master: channels, CSRs, output register.
// Depends on scpm_pkg, scpm_if, scpm_engine.
//
//  channel | dir | word
//  req_    | in  | operation, channel, now, src_address, msg_body, extra_bytes, target_device
//  rsp_    | out | out_channel, kind, address, device, slot, found, status
//  csr_    | in  | write enable, index, data
//
// One item at a time. A table search item takes one sweep on the single read port;
// a tx slot reads and evaluates each live entry it passes; a confirm adds one table
// sweep per candidate of the free address search.
// Reset is synchronous; no clearing pass (entry validity is in flip-flops).
// A waiting result blocks req_ until rsp_ takes it.
`default_nettype none
module shared_channel_poll_master_top import scpm_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   scpm_if.sink     req_ch,
   scpm_if.source   rsp_ch,
   input wire logic                  csr_we,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_wdata
);
   csr_type      csr_ff;
   logic         eng_busy, res_valid;
   rsp_word_type res_word;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   logic         start;

   assign req_ch.ready = !eng_busy && !out_valid_ff;
   assign start = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.net_ident <= 16'd0;
         csr_ff.budget_init <= 8'd8;
         csr_ff.interval <= 16'd1000;
         csr_ff.timeout <= 16'd10000;
         csr_ff.burst <= 8'd3;
         csr_ff.control_code <= 8'd0;
         csr_ff.req_addr_code <= 8'd1;
         csr_ff.confirm_code <= 8'd2;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               R_NET_IDENT:   csr_ff.net_ident <= csr_wdata;
               R_BUDGET_INIT: csr_ff.budget_init <= csr_wdata[7:0];
               R_INTERVAL:    csr_ff.interval <= csr_wdata;
               R_TIMEOUT:     csr_ff.timeout <= csr_wdata;
               R_BURST:       csr_ff.burst <= csr_wdata[7:0];
               R_CONTROL:     csr_ff.control_code <= csr_wdata[7:0];
               R_REQ_ADDR:    csr_ff.req_addr_code <= csr_wdata[7:0];
               R_CONFIRM:     csr_ff.confirm_code <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (res_valid) begin
            out_valid_ff <= 1'b1;
            out_word_ff <= res_word;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   scpm_engine #(.SLOTS(SLOTS)) u_engine (
      .clock(clock), .reset(reset), .csr(csr_ff), .start(start),
      .req(req_ch.data), .busy(eng_busy), .res_valid(res_valid), .res_word(res_word)
   );
endmodule
`default_nettype wire

// ===== rtl/core/scpm_table.sv =====
// Slave table memory: one write port, one read port with a registered read.
// Depends on scpm_pkg.
`default_nettype none
module scpm_table import scpm_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEF,
   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire logic [IW-1:0] wr_idx,
   input  wire entry_type wr_data,
   input  wire logic [IW-1:0] rd_idx,
   output entry_type      rd_data
);
   entry_type mem [SLOTS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end
endmodule
`default_nettype wire

// ===== rtl/core/scpm_engine.sv =====
// Sequencer of the poll master: sweeps the table memory, one entry a cycle in a scan.
// Depends on scpm_pkg and scpm_table.
`default_nettype none
module scpm_engine import scpm_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEF,
   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int unsigned CW = $clog2(SLOTS + 1)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire csr_type      csr,
   input  wire logic         start,
   input  wire req_word_type req,
   output logic              busy,
   output logic              res_valid,
   output rsp_word_type      res_word
);
   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_WALK_RD, S_WALK_WAIT, S_WALK_EVAL,
      S_ADV_SCAN, S_ADV_WAIT, S_WRITE, S_FINISH
   } state_type;

   state_type    state_ff;
   req_word_type req_ff;
   logic [SLOTS-1:0] valid_ff;
   logic [IW-1:0] idx_ff;
   logic [CW-1:0] cursor_ff;
   logic          phase_ff;
   logic [7:0]    budget_ff;
   logic [31:0]   pend_ff;
   logic          alt_ff;
   logic [15:0]   nfa_ff;
   logic [15:0]   cand_ff;
   // scan results
   logic          hit_addr_ff, hit_dev_ff;
   logic [IW-1:0] addr_slot_ff, dev_slot_ff;
   logic          in_use_ff;
   logic          free_ok_ff;
   logic [IW-1:0] free_slot_ff;
   logic          dev_pend_hit_ff;
   logic [IW-1:0] dev_pend_slot_ff;
   // entry being modified
   entry_type     ent_ff;
   logic [IW-1:0] ent_idx_ff;
   logic          adv_after_ff;

   logic          wr_en;
   logic [IW-1:0] rd_idx;
   entry_type     rd_data;

   scpm_table #(.SLOTS(SLOTS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_idx(ent_idx_ff), .wr_data(ent_ff),
      .rd_idx(rd_idx), .rd_data(rd_data)
   );

   // index of the entry read last cycle
   logic [IW-1:0] prev_idx_ff;

   function automatic logic [CW-1:0] next_valid(input logic [SLOTS-1:0] v,
                                                 input logic [CW-1:0] from);
      logic [CW-1:0] r;
      r = CW'(SLOTS);
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i] && (CW'(i) >= from)) begin
            r = CW'(i);
         end
      end
      return r;
   endfunction

   logic [7:0] b0;
   assign b0 = req_ff.msg_body[7:0];
   logic is_sig;
   assign is_sig = (req_ff.src_address == ADDR_BCAST) || (req_ff.src_address == ADDR_SIG2);

   rsp_word_type blank;
   always_comb begin
      blank = '0;
      blank.out_channel = req_ff.channel;
   end

   always_comb begin
      rd_idx = idx_ff;
      if (state_ff == S_WALK_RD) begin
         rd_idx = cursor_ff[IW-1:0];
      end
   end
   assign wr_en = (state_ff == S_WRITE);
   assign busy = (state_ff != S_IDLE);

   logic [31:0] expire;
   assign expire = rd_data.last_rx + 32'(rd_data.timeout);

   always_ff @(posedge clock) begin
      prev_idx_ff <= rd_idx;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         cursor_ff <= CW'(SLOTS);
         phase_ff <= 1'b0;
         budget_ff <= '0;
         pend_ff <= '0;
         alt_ff <= 1'b0;
         nfa_ff <= 16'd1;
         res_valid <= 1'b0;
      end else begin
         res_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req;
                  idx_ff <= '0;
                  hit_addr_ff <= 1'b0;
                  hit_dev_ff <= 1'b0;
                  dev_pend_hit_ff <= 1'b0;
                  adv_after_ff <= 1'b0;
                  state_ff <= S_SCAN;
                  if (req.operation == OP_TX_SLOT) begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_SCAN: begin
               // issue reads of all entries; compare each read in the cycle after it is issued
               if (idx_ff == IW'(SLOTS - 1)) begin
                  state_ff <= S_SCAN_WAIT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
               if (idx_ff != '0) begin
                  if (valid_ff[prev_idx_ff] && !hit_addr_ff &&
                      rd_data.address == req_ff.src_address) begin
                     hit_addr_ff <= 1'b1; addr_slot_ff <= prev_idx_ff;
                  end
                  if (valid_ff[prev_idx_ff] && !hit_dev_ff &&
                      rd_data.device == req_ff.target_device) begin
                     hit_dev_ff <= 1'b1; dev_slot_ff <= prev_idx_ff;
                  end
                  if (valid_ff[prev_idx_ff] && !dev_pend_hit_ff &&
                      rd_data.device == pend_ff) begin
                     dev_pend_hit_ff <= 1'b1; dev_pend_slot_ff <= prev_idx_ff;
                  end
               end
            end
            S_SCAN_WAIT: begin
               if (valid_ff[prev_idx_ff] && !hit_addr_ff &&
                   rd_data.address == req_ff.src_address) begin
                  hit_addr_ff <= 1'b1; addr_slot_ff <= prev_idx_ff;
               end
               if (valid_ff[prev_idx_ff] && !hit_dev_ff &&
                   rd_data.device == req_ff.target_device) begin
                  hit_dev_ff <= 1'b1; dev_slot_ff <= prev_idx_ff;
               end
               if (valid_ff[prev_idx_ff] && !dev_pend_hit_ff &&
                   rd_data.device == pend_ff) begin
                  dev_pend_hit_ff <= 1'b1; dev_pend_slot_ff <= prev_idx_ff;
               end
               free_ok_ff <= ~&valid_ff;
               free_slot_ff <= '0;
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (!valid_ff[i]) free_slot_ff <= IW'(i);
               end
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_FINISH;
               case (req_ff.operation)
                  OP_TX_SLOT: begin
                     if (budget_ff != 8'd0) begin
                        budget_ff <= budget_ff - 8'd1;
                        if (phase_ff) begin
                           res_word <= blank;
                           res_word.kind <= K_BUSY;
                           res_word.device <= pend_ff;
                           res_valid <= 1'b1;
                        end
                     end else begin
                        phase_ff <= 1'b0;
                        state_ff <= S_WALK_RD;
                     end
                  end
                  OP_BCAST, OP_ACK, OP_BURST: begin
                     if (is_sig) begin
                        if (req_ff.extra_bytes) begin
                           // discarded
                        end else if (!phase_ff) begin
                           if (b0 == csr.req_addr_code) begin
                              phase_ff <= 1'b1;
                              pend_ff <= req_ff.msg_body[47:16];
                              budget_ff <= csr.budget_init;
                           end
                        end else if (b0 == csr.confirm_code) begin
                           if (dev_pend_hit_ff) begin
                              idx_ff <= dev_pend_slot_ff;
                              state_ff <= S_WALK_WAIT;
                              ent_idx_ff <= dev_pend_slot_ff;
                           end else if (free_ok_ff) begin
                              valid_ff[free_slot_ff] <= 1'b1;
                              ent_idx_ff <= free_slot_ff;
                              ent_ff.device <= pend_ff;
                              ent_ff.address <= nfa_ff;
                              ent_ff.last_rx <= req_ff.now;
                              ent_ff.interval <= csr.interval;
                              ent_ff.timeout <= csr.timeout;
                              ent_ff.burst <= csr.burst;
                              ent_ff.poll_tally <= '0;
                              ent_ff.due_at <= '0;
                              res_word <= blank;
                              res_word.kind <= K_NEW_SLAVE;
                              res_word.address <= nfa_ff;
                              res_word.device <= pend_ff;
                              res_word.slot <= 4'(free_slot_ff);
                              res_valid <= 1'b1;
                              adv_after_ff <= 1'b1;
                              state_ff <= S_WRITE;
                           end else begin
                              // table full: nothing to write, only the address search
                              cand_ff <= nfa_ff + 16'd1;
                              idx_ff <= '0;
                              in_use_ff <= 1'b0;
                              state_ff <= S_ADV_SCAN;
                           end
                           budget_ff <= '0;
                           pend_ff <= '0;
                        end
                     end else if (req_ff.operation == OP_BCAST) begin
                        if (hit_addr_ff && b0 == csr.control_code) begin
                           idx_ff <= addr_slot_ff;
                           ent_idx_ff <= addr_slot_ff;
                           state_ff <= S_WALK_WAIT;
                        end
                     end else begin
                        res_word <= blank;
                        res_word.kind <= K_DATA;
                        res_word.address <= req_ff.src_address;
                        res_word.found <= hit_addr_ff;
                        res_word.slot <= hit_addr_ff ? 4'(addr_slot_ff) : 4'd0;
                        if (hit_addr_ff) begin
                           idx_ff <= addr_slot_ff;
                           ent_idx_ff <= addr_slot_ff;
                           state_ff <= S_WALK_WAIT;
                        end else begin
                           res_valid <= 1'b1;
                        end
                     end
                  end
                  OP_SEND: begin
                     if (hit_dev_ff) begin
                        idx_ff <= dev_slot_ff;
                        ent_idx_ff <= dev_slot_ff;
                        state_ff <= S_WALK_WAIT;
                     end else begin
                        res_word <= blank;
                        res_word.kind <= K_URGENT;
                        res_word.status <= ST_UNKNOWN;
                        res_valid <= 1'b1;
                     end
                  end
                  OP_CLOSED: begin
                     res_word <= blank;
                     res_word.kind <= K_CLOSED;
                     res_valid <= 1'b1;
                  end
                  default: ;
               endcase
            end
            S_WALK_RD: begin
               if (cursor_ff >= CW'(SLOTS)) begin
                  alt_ff <= ~alt_ff;
                  res_word <= blank;
                  res_valid <= 1'b1;
                  if (alt_ff) begin
                     res_word.kind <= K_ADDR_AVAIL;
                     res_word.address <= nfa_ff;
                  end else begin
                     res_word.kind <= K_CHAN_AVAIL;
                     res_word.address <= csr.net_ident;
                     cursor_ff <= next_valid(valid_ff, '0);
                  end
                  state_ff <= S_FINISH;
               end else if (!valid_ff[cursor_ff[IW-1:0]]) begin
                  cursor_ff <= next_valid(valid_ff, cursor_ff + 1'b1);
               end else begin
                  ent_idx_ff <= cursor_ff[IW-1:0];
                  state_ff <= S_WALK_EVAL;
               end
            end
            S_WALK_WAIT: begin
               // memory read of idx_ff issued; data next cycle
               state_ff <= S_WALK_EVAL;
            end
            S_WALK_EVAL: begin
               ent_ff <= rd_data;
               state_ff <= S_WRITE;
               case (req_ff.operation)
                  OP_TX_SLOT: begin
                     if (req_ff.now > expire) begin
                        valid_ff[ent_idx_ff] <= 1'b0;
                        cursor_ff <= next_valid(valid_ff, cursor_ff + 1'b1);
                        state_ff <= S_WALK_RD;
                     end else if (req_ff.now < rd_data.due_at) begin
                        cursor_ff <= next_valid(valid_ff, cursor_ff + 1'b1);
                        state_ff <= S_WALK_RD;
                     end else begin
                        res_word <= blank;
                        res_word.address <= rd_data.address;
                        res_word.slot <= 4'(ent_idx_ff);
                        res_valid <= 1'b1;
                        if (rd_data.poll_tally == 8'd1) begin
                           res_word.kind <= K_POLL_BEGIN;
                        end else if ({1'b0, rd_data.poll_tally} + 9'd1 <
                                     {1'b0, rd_data.burst}) begin
                           res_word.kind <= K_POLL;
                        end else begin
                           res_word.kind <= K_POLL_END;
                        end
                        if (rd_data.poll_tally + 8'd1 >= rd_data.burst) begin
                           ent_ff.poll_tally <= '0;
                           ent_ff.due_at <= req_ff.now + 32'(rd_data.interval);
                           cursor_ff <= next_valid(valid_ff, cursor_ff + 1'b1);
                        end else begin
                           ent_ff.poll_tally <= rd_data.poll_tally + 8'd1;
                        end
                     end
                  end
                  OP_BCAST, OP_ACK, OP_BURST: begin
                     if (is_sig) begin
                        ent_ff.address <= nfa_ff;
                        ent_ff.last_rx <= req_ff.now;
                        adv_after_ff <= 1'b1;
                     end else if (req_ff.operation == OP_BCAST) begin
                        ent_ff.timeout <= req_ff.msg_body[39:24];
                        ent_ff.burst <= req_ff.msg_body[47:40];
                        if (rd_data.interval != req_ff.msg_body[23:8]) begin
                           ent_ff.interval <= req_ff.msg_body[23:8];
                           ent_ff.due_at <= req_ff.now + 32'(req_ff.msg_body[23:8]);
                        end
                     end else begin
                        res_word.device <= rd_data.device;
                        res_valid <= 1'b1;
                        if (req_ff.operation == OP_BURST) begin
                           ent_ff.last_rx <= req_ff.now;
                        end
                     end
                  end
                  default: begin
                     // send request
                     res_word <= blank;
                     res_word.kind <= K_URGENT;
                     res_word.device <= rd_data.device;
                     res_word.slot <= 4'(ent_idx_ff);
                     res_valid <= 1'b1;
                     if (rd_data.address == 16'd0) begin
                        res_word.status <= ST_NO_ADDR;
                        state_ff <= S_FINISH;
                     end else begin
                        res_word.address <= rd_data.address;
                        ent_ff.due_at <= '0;
                        ent_ff.poll_tally <= 8'd2;
                        if (cursor_ff >= CW'(SLOTS)) begin
                           cursor_ff <= CW'(ent_idx_ff);
                        end
                     end
                  end
               endcase
            end
            S_WRITE: begin
               // write-back; free address search follows if needed
               if (adv_after_ff) begin
                  cand_ff <= nfa_ff + 16'd1;
                  idx_ff <= '0;
                  in_use_ff <= 1'b0;
                  state_ff <= S_ADV_SCAN;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_ADV_SCAN: begin
               if (idx_ff == IW'(SLOTS - 1)) begin
                  state_ff <= S_ADV_WAIT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
               if (idx_ff != '0 && valid_ff[prev_idx_ff] && rd_data.address == cand_ff) begin
                  in_use_ff <= 1'b1;
               end
            end
            S_ADV_WAIT: begin
               // one candidate per table sweep
               if ((in_use_ff || (valid_ff[prev_idx_ff] && rd_data.address == cand_ff)) ||
                   cand_ff == 16'd0 || cand_ff == ADDR_SIG2 || cand_ff == ADDR_BCAST) begin
                  cand_ff <= cand_ff + 16'd1;
                  idx_ff <= '0;
                  in_use_ff <= 1'b0;
                  state_ff <= S_ADV_SCAN;
               end else begin
                  nfa_ff <= cand_ff;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/scpm_checker.sv =====
// Port-level checker of the poll master, bound to the top level.
// Depends on scpm_pkg and the macro header.
`default_nettype none
`include "shared_channel_poll_master_top_macros.svh"
module scpm_checker import scpm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [3:0] kind,
   input wire logic [1:0] status,
   input wire logic found
);
   // a word is never taken while a result waits
   `SCPM_ASSERT_IMP(a_no_accept_while_out, clock, reset, rsp_valid, !req_ready)
   // an accepted word blocks the input next cycle
   `SCPM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // status only on urgent polls
   `SCPM_ASSERT_IMP(a_status_kind, clock, reset, rsp_valid && status != 2'd0, kind == K_URGENT)
   // found only on data words
   `SCPM_ASSERT_IMP(a_found_kind, clock, reset, rsp_valid && found, kind == K_DATA)
endmodule

bind shared_channel_poll_master_top scpm_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .kind(rsp_ch.data.kind), .status(rsp_ch.data.status), .found(rsp_ch.data.found)
);
`default_nettype wire
